### hdl/prefix_tree_acceptor_build_core_assert.svh
// Assertion macros shared by the block's modules.
// Each macro expects signals named clk and rst_n in the using scope.
`ifndef PREFIX_TREE_ACCEPTOR_BUILD_CORE_ASSERT_SVH
`define PREFIX_TREE_ACCEPTOR_BUILD_CORE_ASSERT_SVH

// Same-cycle implication.
`define PTAB_ASSERT_NOW(name, pre, post, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error(msg);

// Next-cycle implication.
`define PTAB_ASSERT_NEXT(name, pre, post, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error(msg);

`endif

### hdl/ptab_pkg.sv
`timescale 1ns / 1ps

package ptab_pkg;

    localparam int MAX_STATES_DEF    = 4096;
    localparam int ALPHABET_SIZE_DEF = 4;

    typedef logic [11:0] state_field_t;
    typedef logic [12:0] count_field_t;

    typedef enum logic [1:0] {
        REQ_SYMBOL = 2'd0,
        REQ_EMPTY  = 2'd1,
        REQ_READ   = 2'd2,
        REQ_UNUSED = 2'd3
    } req_t;

    typedef enum logic [1:0] {
        ST_REJ = 2'd0,
        ST_ACC = 2'd1,
        ST_UNK = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        ERR_NONE         = 2'd0,
        ERR_ACC_OVER_REJ = 2'd1,
        ERR_REJ_OVER_ACC = 2'd2,
        ERR_FULL         = 2'd3
    } err_t;

    typedef struct packed {
        logic [1:0]   req_type;
        logic [1:0]   symbol;
        logic         first_symbol;
        logic         last_symbol;
        logic [1:0]   label;
        state_field_t read_state;
    } item_t;

    typedef struct packed {
        state_field_t reached_state;
        logic         created;
        logic         skipped;
        logic [1:0]   error_code;
        count_field_t state_count;
        logic [1:0]   read_status;
        state_field_t read_target;
        logic         read_valid;
    } result_t;

    typedef enum logic [1:0] {
        CTRL_CLEAR = 2'd0,
        CTRL_IDLE  = 2'd1,
        CTRL_EXEC  = 2'd2
    } ctrl_state_t;

    // Controller to datapath
    typedef struct packed {
        logic accept;      // latch item, launch table reads
        logic finish;      // commit updates, load result register
        logic clear_step;  // write one zero entry of the transition table
    } cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic clear_last;  // clearing pass at final entry
        logic out_free;    // result register can take a new transaction
    } dp_status_t;

endpackage

### hdl/ptab_ram.sv
`timescale 1ns / 1ps

module ptab_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

### hdl/ptab_ctrl.sv
`timescale 1ns / 1ps

module ptab_ctrl (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   item_valid,
    output logic                   item_stall,
    input  ptab_pkg::dp_status_t   dp_status,
    output ptab_pkg::cmd_t         cmd
);

`include "prefix_tree_acceptor_build_core_assert.svh"

    ptab_pkg::ctrl_state_t state_reg;
    ptab_pkg::ctrl_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ptab_pkg::CTRL_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ptab_pkg::CTRL_CLEAR:
            begin
                if (dp_status.clear_last)
                begin
                    state_next = ptab_pkg::CTRL_IDLE;
                end
            end
            ptab_pkg::CTRL_IDLE:
            begin
                if (item_valid)
                begin
                    state_next = ptab_pkg::CTRL_EXEC;
                end
            end
            ptab_pkg::CTRL_EXEC:
            begin
                if (dp_status.out_free)
                begin
                    state_next = ptab_pkg::CTRL_IDLE;
                end
            end
            default:
            begin
                state_next = ptab_pkg::CTRL_CLEAR;
            end
        endcase
    end

    always_comb
    begin
        item_stall     = 1'b1;
        cmd.accept     = 1'b0;
        cmd.finish     = 1'b0;
        cmd.clear_step = 1'b0;
        case (state_reg)
            ptab_pkg::CTRL_CLEAR:
            begin
                cmd.clear_step = 1'b1;
            end
            ptab_pkg::CTRL_IDLE:
            begin
                item_stall = 1'b0;
                cmd.accept = item_valid;
            end
            ptab_pkg::CTRL_EXEC:
            begin
                cmd.finish = dp_status.out_free;
            end
            default:
            begin
                item_stall = 1'b1;
            end
        endcase
    end

    `PTAB_ASSERT_NEXT(a_accept_to_exec, cmd.accept, state_reg == ptab_pkg::CTRL_EXEC, "accepted transaction did not enter execute")
    `PTAB_ASSERT_NEXT(a_finish_to_idle, cmd.finish, state_reg == ptab_pkg::CTRL_IDLE, "finished transaction did not return to idle")
    `PTAB_ASSERT_NEXT(a_exec_waits, (state_reg == ptab_pkg::CTRL_EXEC) && !dp_status.out_free, state_reg == ptab_pkg::CTRL_EXEC && item_stall, "execute left while result register busy")

endmodule

### hdl/ptab_dp.sv
`timescale 1ns / 1ps

module ptab_dp #(
    parameter int MAX_STATES    = ptab_pkg::MAX_STATES_DEF,
    parameter int ALPHABET_SIZE = ptab_pkg::ALPHABET_SIZE_DEF
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  ptab_pkg::item_t        item,
    input  logic                   cfg_write,
    input  logic                   cfg_data,
    input  ptab_pkg::cmd_t         cmd,
    output ptab_pkg::dp_status_t   dp_status,
    output logic                   result_valid,
    input  logic                   result_stall,
    output ptab_pkg::result_t      result
);

`include "prefix_tree_acceptor_build_core_assert.svh"

    localparam int SW    = $clog2(MAX_STATES);
    localparam int CW    = $clog2(MAX_STATES + 1);
    localparam int DEPTH = MAX_STATES * ALPHABET_SIZE;
    localparam int EAW   = $clog2(DEPTH);
    // edge entry: valid, target, status of target
    localparam int EW    = SW + 3;

    // Configuration and walk state
    logic              aug_reg;
    logic [SW-1:0]     walk_reg,  walk_next;
    logic [CW-1:0]     count_reg, count_next;
    logic              seen_reg,  seen_next;
    ptab_pkg::err_t    err_reg,   err_next;
    logic [1:0]        root_reg,  root_next;
    logic [EAW-1:0]    clear_addr_reg;

    // Item being worked on
    ptab_pkg::item_t   item_reg;
    logic [SW-1:0]     pos_reg;
    logic [EAW-1:0]    idx_reg;

    // Result register
    ptab_pkg::result_t result_reg, res_next;
    logic              result_valid_reg;

    // Memory ports
    logic              edge_we;
    logic [EAW-1:0]    edge_waddr;
    logic [EW-1:0]     edge_wdata;
    logic [EAW-1:0]    edge_raddr;
    logic [EW-1:0]     edge_q;
    logic              st_we;
    logic [SW-1:0]     st_waddr;
    logic [1:0]        st_wdata;
    logic [1:0]        st_q;

    logic              exec_edge_we;
    logic [EW-1:0]     exec_edge_wdata;

    logic [SW-1:0]     sel_pos;
    logic [SW-1:0]     rd_state;

    logic              q_valid;
    logic [SW-1:0]     q_target;
    logic [1:0]        q_status;
    logic              sym_oob;
    logic              rd_in_range;
    logic              skip;
    logic [1:0]        verdict;
    logic [SW-1:0]     new_state;

    assign q_valid  = edge_q[EW-1];
    assign q_target = edge_q[SW+1:2];
    assign q_status = edge_q[1:0];

    // Launch address: walk restarts at the root on the first symbol; reads use read_state
    always_comb
    begin
        if (item.first_symbol && (item.req_type == ptab_pkg::REQ_SYMBOL))
        begin
            sel_pos = '0;
        end
        else
        begin
            sel_pos = walk_reg;
        end
        if (item.req_type == ptab_pkg::REQ_READ)
        begin
            rd_state = SW'(item.read_state);
        end
        else
        begin
            rd_state = sel_pos;
        end
        edge_raddr = EAW'(rd_state) * EAW'(ALPHABET_SIZE) + EAW'(item.symbol);
    end

    assign sym_oob     = 32'(item_reg.symbol) >= 32'(ALPHABET_SIZE);
    assign rd_in_range = (32'(item_reg.read_state) < 32'(MAX_STATES)) && !sym_oob;
    assign skip        = (!aug_reg && (item_reg.label != ptab_pkg::ST_ACC)) || sym_oob;
    assign verdict     = (item_reg.label == ptab_pkg::ST_ACC) ? ptab_pkg::ST_ACC
                                                               : ptab_pkg::ST_REJ;
    assign new_state   = SW'(count_reg);

    always_comb
    begin
        walk_next       = walk_reg;
        count_next      = count_reg;
        seen_next       = seen_reg;
        err_next        = err_reg;
        root_next       = root_reg;
        exec_edge_we    = 1'b0;
        exec_edge_wdata = edge_q;
        st_we           = 1'b0;
        st_waddr        = q_target;
        st_wdata        = verdict;

        res_next               = '0;
        res_next.reached_state = '0;

        case (item_reg.req_type)
            ptab_pkg::REQ_SYMBOL:
            begin
                seen_next = 1'b1;
                walk_next = pos_reg;
                if (skip)
                begin
                    res_next.skipped = 1'b1;
                end
                else if (q_valid)
                begin
                    walk_next = q_target;
                    if (item_reg.last_symbol)
                    begin
                        if ((verdict == ptab_pkg::ST_ACC) && (q_status == ptab_pkg::ST_REJ))
                        begin
                            if (err_reg == ptab_pkg::ERR_NONE)
                            begin
                                err_next = ptab_pkg::ERR_ACC_OVER_REJ;
                            end
                        end
                        else if ((verdict == ptab_pkg::ST_REJ) &&
                                 (q_status == ptab_pkg::ST_ACC))
                        begin
                            if (err_reg == ptab_pkg::ERR_NONE)
                            begin
                                err_next = ptab_pkg::ERR_REJ_OVER_ACC;
                            end
                        end
                        else
                        begin
                            exec_edge_we    = 1'b1;
                            exec_edge_wdata = {1'b1, q_target, verdict};
                            st_we           = 1'b1;
                        end
                    end
                    res_next.reached_state = ptab_pkg::state_field_t'(walk_next);
                end
                else if (32'(count_reg) >= 32'(MAX_STATES))
                begin
                    if (err_reg == ptab_pkg::ERR_NONE)
                    begin
                        err_next = ptab_pkg::ERR_FULL;
                    end
                    res_next.reached_state = ptab_pkg::state_field_t'(pos_reg);
                end
                else
                begin
                    st_waddr        = new_state;
                    st_wdata        = item_reg.last_symbol ? verdict : 2'(ptab_pkg::ST_UNK);
                    st_we           = 1'b1;
                    exec_edge_we    = 1'b1;
                    exec_edge_wdata = {1'b1, new_state, st_wdata};
                    count_next      = count_reg + CW'(1);
                    walk_next       = new_state;
                    res_next.created       = 1'b1;
                    res_next.reached_state = ptab_pkg::state_field_t'(new_state);
                end
            end
            ptab_pkg::REQ_EMPTY:
            begin
                if (!seen_reg)
                begin
                    root_next = verdict;
                end
                seen_next = 1'b1;
                walk_next = '0;
            end
            ptab_pkg::REQ_READ:
            begin
                res_next.reached_state = item_reg.read_state;
                if (rd_in_range)
                begin
                    res_next.read_status = (item_reg.read_state == '0) ? root_reg : st_q;
                    res_next.read_valid  = q_valid;
                    res_next.read_target = q_valid ? ptab_pkg::state_field_t'(q_target)
                                                   : '0;
                end
            end
            default:
            begin
                res_next.skipped = 1'b1;
            end
        endcase

        res_next.error_code  = err_next;
        res_next.state_count = ptab_pkg::count_field_t'(count_next);
    end

    // Transition table write port: clearing pass or commit
    always_comb
    begin
        if (cmd.clear_step)
        begin
            edge_we    = 1'b1;
            edge_waddr = clear_addr_reg;
            edge_wdata = '0;
        end
        else
        begin
            edge_we    = cmd.finish && exec_edge_we;
            edge_waddr = idx_reg;
            edge_wdata = exec_edge_wdata;
        end
    end

    ptab_ram #(
        .WIDTH (EW),
        .DEPTH (DEPTH)
    ) u_edge_ram (
        .clk   (clk),
        .we    (edge_we),
        .waddr (edge_waddr),
        .wdata (edge_wdata),
        .re    (cmd.accept),
        .raddr (edge_raddr),
        .rdata (edge_q)
    );

    ptab_ram #(
        .WIDTH (2),
        .DEPTH (MAX_STATES)
    ) u_status_ram (
        .clk   (clk),
        .we    (cmd.finish && st_we),
        .waddr (st_waddr),
        .wdata (st_wdata),
        .re    (cmd.accept),
        .raddr (SW'(item.read_state)),
        .rdata (st_q)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            aug_reg          <= 1'b1;
            walk_reg         <= '0;
            count_reg        <= CW'(1);
            seen_reg         <= 1'b0;
            err_reg          <= ptab_pkg::ERR_NONE;
            root_reg         <= ptab_pkg::ST_UNK;
            clear_addr_reg   <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_write)
            begin
                aug_reg <= cfg_data;
            end
            if (cmd.clear_step)
            begin
                clear_addr_reg <= clear_addr_reg + EAW'(1);
            end
            if (cmd.finish)
            begin
                walk_reg         <= walk_next;
                count_reg        <= count_next;
                seen_reg         <= seen_next;
                err_reg          <= err_next;
                root_reg         <= root_next;
                result_valid_reg <= 1'b1;
            end
            else if (!result_stall)
            begin
                result_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            item_reg <= item;
            pos_reg  <= sel_pos;
            idx_reg  <= edge_raddr;
        end
        if (cmd.finish)
        begin
            result_reg <= res_next;
        end
    end

    assign dp_status.clear_last = (clear_addr_reg == EAW'(DEPTH - 1));
    assign dp_status.out_free   = !result_valid_reg || !result_stall;
    assign result_valid         = result_valid_reg;
    assign result               = result_reg;

    `PTAB_ASSERT_NOW(a_count_bounded, 1'b1, (32'(count_reg) <= 32'(MAX_STATES)) && (count_reg != '0), "state count out of range")
    `PTAB_ASSERT_NEXT(a_error_sticky, err_reg != ptab_pkg::ERR_NONE, err_reg == $past(err_reg), "sticky error changed")
    `PTAB_ASSERT_NEXT(a_create_counts, cmd.finish && res_next.created, count_reg == $past(count_reg) + CW'(1), "created state not counted")
    `PTAB_ASSERT_NOW(a_no_write_in_clear, cmd.clear_step, !cmd.finish && !cmd.accept, "table access during clearing pass")

endmodule

### hdl/prefix_tree_acceptor_build_core.sv
`timescale 1ns / 1ps

// Channel   Handshake                  Payload
// item      item_valid / item_stall    ptab_pkg::item_t   (symbol, empty string, read)
// result    result_valid / result_stall ptab_pkg::result_t (one per item)
// config    cfg_write                  cfg_data           (augmented mode)
//
// For each item the transition and status tables are read in the accept cycle;
// commit and result load follow in the execute state, once the output frees.
// The walk from one symbol to the next runs through that read-then-write loop.
// After reset a clearing pass zeroes the transition table, one entry per cycle,
// MAX_STATES * ALPHABET_SIZE entries (16384 by default); item_stall stays high.
// A stalled result holds in the output register; the next item is still
// accepted and waits in its commit cycle until the register frees.

module prefix_tree_acceptor_build_core #(
    parameter int MAX_STATES    = ptab_pkg::MAX_STATES_DEF,
    parameter int ALPHABET_SIZE = ptab_pkg::ALPHABET_SIZE_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              item_valid,
    output logic              item_stall,
    input  ptab_pkg::item_t   item,
    output logic              result_valid,
    input  logic              result_stall,
    output ptab_pkg::result_t result,
    input  logic              cfg_write,
    input  logic              cfg_data
);

    // Command and status between sequencer and datapath
    ptab_pkg::cmd_t       cmd;
    ptab_pkg::dp_status_t dp_status;

    // Sequence clearing pass, accept, and commit
    ptab_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_stall (item_stall),
        .dp_status  (dp_status),
        .cmd        (cmd)
    );

    // Tables, walk state, error tracking, and the result register
    ptab_dp #(
        .MAX_STATES    (MAX_STATES),
        .ALPHABET_SIZE (ALPHABET_SIZE)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .item         (item),
        .cfg_write    (cfg_write),
        .cfg_data     (cfg_data),
        .cmd          (cmd),
        .dp_status    (dp_status),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

endmodule
